// ----- rtl/core/dual_circular_convolution_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dual circular convolution core
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef DUAL_CIRCULAR_CONVOLUTION_CORE_DEFINES_SVH
`define DUAL_CIRCULAR_CONVOLUTION_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a condition holds at every clock edge outside reset.
`define DCC_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a trigger is followed by a condition in the next cycle.
`define DCC_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);
`else
`define DCC_ASSERT(lbl, clk, rst_n, cond, msg)
`define DCC_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg)
`endif

`endif

// ----- rtl/core/dcc_pkg.sv -----
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared constants, item codes and control structs of the convolution core.
// ----------------------------------------------------------------------------
package dcc_pkg;

    localparam int WINDOW_SIZE_DEF = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int INDEX_W = 8;
    localparam int IN_SAMPLE_W = 16;
    localparam int RES_W = 40;

    localparam logic signed [63:0] RES_MAX = 64'sh0000_007F_FFFF_FFFF;
    localparam logic signed [63:0] RES_MIN = -64'sh0000_0080_0000_0000;

    localparam logic [1:0] KIND_LOAD_WIN = 2'd0;
    localparam logic [1:0] KIND_LOAD_SIG = 2'd1;
    localparam logic [1:0] KIND_COMPUTE  = 2'd2;
    localparam logic [1:0] KIND_READ     = 2'd3;

    typedef struct packed {
        logic issue;     // read a[k], b[j], c[j] for one product
        logic first;     // first term of a sum
        logic last;      // last term of a sum
        logic load_win;  // write window sample at index
        logic load_sig;  // write signal pair at index
        logic read_res;  // load output register from result stores
    } dcc_cmd_t;

    typedef struct packed {
        logic pipe_busy; // products still in flight
        logic out_busy;  // output register holds an item
    } dcc_status_t;

endpackage

// ----- rtl/core/dual_circular_convolution_core.sv -----
// Loads write their store on accept; a read shows its result the cycle after accept.
// Compute item: input stalls from accept through the sweep and drain, one product
//   pair per cycle through the shared dual multiply-accumulate.
// Throughput: loads and reads 1 item per cycle unless the output holds a result under out_stall.
// Reset: rst_n async active low clears control and output valid; stores undefined.
// ----------------------------------------------------------------------------
// dual_circular_convolution_core
// Direct circular convolution of a stored window with two signals.
// ----------------------------------------------------------------------------
module dual_circular_convolution_core
    import dcc_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic [INDEX_W-1:0]            index,
    input  logic signed [IN_SAMPLE_W-1:0] window_sample,
    input  logic signed [IN_SAMPLE_W-1:0] b_sample,
    input  logic signed [IN_SAMPLE_W-1:0] c_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [INDEX_W-1:0]            out_index,
    output logic signed [RES_W-1:0]       ab_value,
    output logic signed [RES_W-1:0]       ac_value
);

    localparam int AW = $clog2(WINDOW_SIZE);

    // commands from the sequencer, status back from the datapath
    dcc_cmd_t      cmd;
    dcc_status_t   status;
    logic [AW-1:0] addr_k;
    logic [AW-1:0] addr_j;
    logic [AW-1:0] addr_n;

    // Sequence the sweep: for each n, walk k over the window while j runs
    // down from n with wraparound, so j = (n - k) mod WINDOW_SIZE.
    dcc_controller #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .addr_k    (addr_k),
        .addr_j    (addr_j),
        .addr_n    (addr_n)
    );

    // Hold the stores, form a[k]*b[j] and a[k]*c[j], accumulate exact sums
    // and saturate them to 40 bits on write-back.
    dcc_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .addr_k        (addr_k),
        .addr_j        (addr_j),
        .addr_n        (addr_n),
        .index         (index),
        .window_sample (window_sample),
        .b_sample      (b_sample),
        .c_sample      (c_sample),
        .out_stall     (out_stall),
        .status        (status),
        .out_valid     (out_valid),
        .out_index     (out_index),
        .ab_value      (ab_value),
        .ac_value      (ac_value)
    );

endmodule

// ----- rtl/core/dcc_controller.sv -----
// ----------------------------------------------------------------------------
// dcc_controller
// Accepts items and sequences the n/k sweep of a compute item.
// ----------------------------------------------------------------------------
module dcc_controller
    import dcc_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    localparam int AW = $clog2(WINDOW_SIZE)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    kind,
    input  logic          out_stall,
    input  dcc_status_t   status,
    output dcc_cmd_t      cmd,
    output logic [AW-1:0] addr_k,
    output logic [AW-1:0] addr_j,
    output logic [AW-1:0] addr_n
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_SIZE - 1);

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] n_reg, n_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] j_reg, j_next;
    logic          accept;
    logic          start_compute;
    logic          sweep_done;
    logic          busy;

    assign in_stall = (state_reg != ST_IDLE) || (status.out_busy && out_stall);
    assign accept   = in_valid && !in_stall;

    assign start_compute = accept && (kind == KIND_COMPUTE);
    assign sweep_done    = cmd.last && (n_reg == LAST_IDX);
    assign busy          = (state_reg != ST_IDLE) || status.pipe_busy;

    assign addr_k = k_reg;
    assign addr_j = j_reg;
    assign addr_n = n_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.load_win = accept && (kind == KIND_LOAD_WIN);
        cmd.load_sig = accept && (kind == KIND_LOAD_SIG);
        cmd.read_res = accept && (kind == KIND_READ);
        cmd.issue    = (state_reg == ST_RUN);
        cmd.first    = (state_reg == ST_RUN) && (k_reg == '0);
        cmd.last     = (state_reg == ST_RUN) && (k_reg == LAST_IDX);
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_compute)
                begin
                    state_next = ST_RUN;
                    n_next     = '0;
                    k_next     = '0;
                    j_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (k_reg == LAST_IDX)
                begin
                    // start the next output position
                    k_next = '0;
                    n_next = n_reg + 1'b1;
                    j_next = n_reg + 1'b1;
                    if (n_reg == LAST_IDX)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    j_next = (j_reg == '0) ? LAST_IDX : j_reg - 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
        end
    end

`include "dual_circular_convolution_core_defines.svh"

    `DCC_ASSERT_NEXT(a_start, clk, rst_n, start_compute, state_reg == ST_RUN, "no sweep start")
    `DCC_ASSERT_NEXT(a_sweep_end, clk, rst_n, sweep_done, state_reg == ST_DRAIN, "no drain")
    `DCC_ASSERT(a_idle_accept, clk, rst_n, !(accept && busy), "item accepted during compute")

endmodule

// ----- rtl/core/dcc_datapath.sv -----
// ----------------------------------------------------------------------------
// dcc_datapath
// Sample and result stores, dual multiply-accumulate and output register.
// ----------------------------------------------------------------------------
module dcc_datapath
    import dcc_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int AW = $clog2(WINDOW_SIZE)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dcc_cmd_t                      cmd,
    input  logic [AW-1:0]                 addr_k,
    input  logic [AW-1:0]                 addr_j,
    input  logic [AW-1:0]                 addr_n,
    input  logic [INDEX_W-1:0]            index,
    input  logic signed [IN_SAMPLE_W-1:0] window_sample,
    input  logic signed [IN_SAMPLE_W-1:0] b_sample,
    input  logic signed [IN_SAMPLE_W-1:0] c_sample,
    input  logic                          out_stall,
    output dcc_status_t                   status,
    output logic                          out_valid,
    output logic [INDEX_W-1:0]            out_index,
    output logic signed [RES_W-1:0]       ab_value,
    output logic signed [RES_W-1:0]       ac_value
);

    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + AW + 1;

    logic signed [SAMPLE_BITS-1:0] win_mem [WINDOW_SIZE];
    logic signed [SAMPLE_BITS-1:0] b_mem   [WINDOW_SIZE];
    logic signed [SAMPLE_BITS-1:0] c_mem   [WINDOW_SIZE];
    logic signed [RES_W-1:0]       ab_mem  [WINDOW_SIZE];
    logic signed [RES_W-1:0]       ac_mem  [WINDOW_SIZE];

    logic [31:0]             idx32;
    logic [AW-1:0]           io_addr;
    logic                    idx_ok;
    logic [31:0]             win32, b32, c32;

    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                    s1_first_reg, s2_first_reg;
    logic                    s1_last_reg, s2_last_reg;
    logic [AW-1:0]           s1_n_reg, s2_n_reg, s3_n_reg;
    logic signed [SAMPLE_BITS-1:0] a_reg, b_reg, c_reg;
    logic signed [PROD_W-1:0] pb_reg, pc_reg;
    logic signed [ACC_W-1:0] acc_b_reg, acc_c_reg;
    logic signed [ACC_W-1:0] acc_b_next, acc_c_next;
    logic signed [RES_W-1:0] sat_b, sat_c;
    logic                    out_valid_reg;

    function automatic logic signed [RES_W-1:0] sat_res(input logic signed [ACC_W-1:0] v);
        logic signed [63:0] w;
        w = {{(64 - ACC_W){v[ACC_W-1]}}, v};
        if (w > RES_MAX)
            return RES_MAX[RES_W-1:0];
        else if (w < RES_MIN)
            return RES_MIN[RES_W-1:0];
        else
            return w[RES_W-1:0];
    endfunction

    assign idx32   = 32'(index);
    assign io_addr = idx32[AW-1:0];
    assign idx_ok  = idx32 < 32'(WINDOW_SIZE);
    assign win32   = 32'(unsigned'(window_sample));
    assign b32     = 32'(unsigned'(b_sample));
    assign c32     = 32'(unsigned'(c_sample));

    // sample stores: write on load, read for the sweep
    always_ff @(posedge clk)
    begin
        if (cmd.load_win && idx_ok)
            win_mem[io_addr] <= win32[SAMPLE_BITS-1:0];
        if (cmd.load_sig && idx_ok)
        begin
            b_mem[io_addr] <= b32[SAMPLE_BITS-1:0];
            c_mem[io_addr] <= c32[SAMPLE_BITS-1:0];
        end
        a_reg <= win_mem[addr_k];
        b_reg <= b_mem[addr_j];
        c_reg <= c_mem[addr_j];
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last;
        s1_n_reg     <= addr_n;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_n_reg     <= s1_n_reg;
        s3_n_reg     <= s2_n_reg;
        pb_reg       <= a_reg * b_reg;
        pc_reg       <= a_reg * c_reg;
    end

    always_comb
    begin
        acc_b_next = (s2_first_reg ? '0 : acc_b_reg)
                   + {{(ACC_W - PROD_W){pb_reg[PROD_W-1]}}, pb_reg};
        acc_c_next = (s2_first_reg ? '0 : acc_c_reg)
                   + {{(ACC_W - PROD_W){pc_reg[PROD_W-1]}}, pc_reg};
    end

    assign sat_b = sat_res(acc_b_reg);
    assign sat_c = sat_res(acc_c_reg);

    // accumulate, then saturate and store in the cycle after the last term
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            acc_b_reg <= acc_b_next;
            acc_c_reg <= acc_c_next;
        end
        if (s3_valid_reg)
        begin
            ab_mem[s3_n_reg] <= sat_b;
            ac_mem[s3_n_reg] <= sat_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg && s2_last_reg;
        end
    end

    // output register: load on read, drop when taken
    always_ff @(posedge clk)
    begin
        if (cmd.read_res)
        begin
            out_index <= index;
            if (idx_ok)
            begin
                ab_value <= ab_mem[io_addr];
                ac_value <= ac_mem[io_addr];
            end
            else
            begin
                ab_value <= '0;
                ac_value <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.read_res)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid        = out_valid_reg;
    assign status.pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign status.out_busy  = out_valid_reg;

endmodule

// ----- tb/dual_circular_convolution_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual circular convolution core testbench
// Loads the window and both signals, runs compute items and checks every read
// item against an in-bench convolution of the same stores or a value typed in
// the plan, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module dual_circular_convolution_core_tb;
    import dcc_pkg::*;

    localparam int N         = WINDOW_SIZE_DEF;
    localparam int IDLE_MAX  = 200000;  // a compute alone holds input through its whole sweep and drain
    localparam int RAND_ITEMS = 1280;
    localparam int MAX_COMPUTES = 5;

    typedef struct {
        logic [1:0]                    kind;
        logic [INDEX_W-1:0]            index;
        logic signed [IN_SAMPLE_W-1:0] win;
        logic signed [IN_SAMPLE_W-1:0] b;
        logic signed [IN_SAMPLE_W-1:0] c;
        bit                            typed;
        logic signed [RES_W-1:0]       ab;
        logic signed [RES_W-1:0]       ac;
    } plan_row_t;

    typedef struct {
        logic [INDEX_W-1:0]      index;
        logic signed [RES_W-1:0] ab;
        logic signed [RES_W-1:0] ac;
    } conv_result_t;

    // Window at index 0 only, so each result reads off as a0 * signal sample.
    // Load items carry junk in the unused sample fields; the block must ignore it.
    plan_row_t plan [11] = '{
        '{KIND_LOAD_WIN, 8'd0,   -16'sd32768, 16'sh1234,   16'sh4321,   0, '0, '0},
        '{KIND_LOAD_WIN, 8'd255, 16'sd0,      16'sh7FFF,   -16'sd32768, 0, '0, '0},
        '{KIND_LOAD_SIG, 8'd0,   16'sh7FFF,   -16'sd32768, 16'sd32767,  0, '0, '0},
        '{KIND_LOAD_SIG, 8'd255, -16'sd32768, 16'sd32767,  -16'sd32768, 0, '0, '0},
        '{KIND_LOAD_SIG, 8'd128, 16'sh5555,   -16'sd1,     16'sd1,      0, '0, '0},
        '{KIND_COMPUTE,  8'd77,  16'shAAAA,   16'sh5555,   16'shFFFF,   0, '0, '0},
        '{KIND_READ,     8'd0,   16'shFFFF,   16'shFFFF,   16'shFFFF,   1,
          40'sd1073741824, -40'sd1073709056},
        '{KIND_READ,     8'd255, 16'sd0,      16'sd0,      16'sd0,      1,
          -40'sd1073709056, 40'sd1073741824},
        '{KIND_READ,     8'd128, 16'sd0,      16'sd0,      16'sd0,      1,
          40'sd32768, -40'sd32768},
        '{KIND_READ,     8'd1,   16'sd0,      16'sd0,      16'sd0,      1, '0, '0},
        '{KIND_READ,     8'd127, 16'sd0,      16'sd0,      16'sd0,      0, '0, '0}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [1:0]                    kind;
    logic [INDEX_W-1:0]            index;
    logic signed [IN_SAMPLE_W-1:0] window_sample;
    logic signed [IN_SAMPLE_W-1:0] b_sample;
    logic signed [IN_SAMPLE_W-1:0] c_sample;
    logic                          out_valid;
    logic                          out_stall;
    logic [INDEX_W-1:0]            out_index;
    logic signed [RES_W-1:0]       ab_value;
    logic signed [RES_W-1:0]       ac_value;

    // Predictor state: a private copy of every store in the block.
    logic signed [IN_SAMPLE_W-1:0] win_mem [N];
    logic signed [IN_SAMPLE_W-1:0] b_mem   [N];
    logic signed [IN_SAMPLE_W-1:0] c_mem   [N];
    logic signed [RES_W-1:0]       ab_mem  [N];
    logic signed [RES_W-1:0]       ac_mem  [N];

    conv_result_t pending_reads [$];
    int           error_count;
    int           idle_cycles;
    int           burst_left;
    int           computes_done;

    dual_circular_convolution_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .index         (index),
        .window_sample (window_sample),
        .b_sample      (b_sample),
        .c_sample      (c_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_index     (out_index),
        .ab_value      (ab_value),
        .ac_value      (ac_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [RES_W-1:0] clamp_res(longint acc);
        if (acc > RES_MAX)
            return RES_MAX[RES_W-1:0];
        if (acc < RES_MIN)
            return RES_MIN[RES_W-1:0];
        return acc[RES_W-1:0];
    endfunction

    // Recompute both convolutions from the current window and signals.
    function automatic void convolve_stores();
        longint sb;
        longint sc;
        longint a;
        int     j;
        for (int n = 0; n < N; n++)
        begin
            sb = 0;
            sc = 0;
            for (int k = 0; k < N; k++)
            begin
                j  = (n + N - k) % N;
                a  = win_mem[k];
                sb += a * longint'(b_mem[j]);
                sc += a * longint'(c_mem[j]);
            end
            ab_mem[n] = clamp_res(sb);
            ac_mem[n] = clamp_res(sc);
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
    endtask

    // Apply one accepted item to the predictor; queue the result of a read.
    task automatic track_item(input plan_row_t it);
        conv_result_t r;
        case (it.kind)
            KIND_LOAD_WIN: win_mem[it.index] = it.win;
            KIND_LOAD_SIG:
            begin
                b_mem[it.index] = it.b;
                c_mem[it.index] = it.c;
            end
            KIND_COMPUTE: convolve_stores();
            default:
            begin
                r.index = it.index;
                r.ab    = it.typed ? it.ab : ab_mem[it.index];
                r.ac    = it.typed ? it.ac : ac_mem[it.index];
                pending_reads.push_back(r);
            end
        endcase
    endtask

    // Drive one item from a rising edge and hold it until the block takes it.
    // Between bursts, drop valid for a random gap.
    task automatic send_item(input plan_row_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid      <= 1'b1;
        kind          <= it.kind;
        index         <= it.index;
        window_sample <= it.win;
        b_sample      <= it.b;
        c_sample      <= it.c;
        do
            @(posedge clk);
        while (in_stall);
        track_item(it);
    endtask

    function automatic plan_row_t random_item();
        plan_row_t it;
        int        pick;
        it.index = INDEX_W'($urandom_range(0, N - 1));
        it.win   = IN_SAMPLE_W'($urandom);
        it.b     = IN_SAMPLE_W'($urandom);
        it.c     = IN_SAMPLE_W'($urandom);
        it.typed = 0;
        it.ab    = '0;
        it.ac    = '0;
        // Mix in the extremes now and then so that sums reach their largest values.
        if ($urandom_range(0, 9) == 0)
            it.win = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        if ($urandom_range(0, 9) == 0)
            it.b = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        if ($urandom_range(0, 9) == 0)
            it.c = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        pick = $urandom_range(0, 999);
        if (pick < 4 && computes_done < MAX_COMPUTES)
        begin
            it.kind = KIND_COMPUTE;
            computes_done++;
        end
        else if (pick < 380)
            it.kind = KIND_LOAD_WIN;
        else if (pick < 680)
            it.kind = KIND_LOAD_SIG;
        else
            it.kind = KIND_READ;
        return it;
    endfunction

    // Receiver stall: switch at random among no stall, light and heavy modes.
    int unsigned stall_mode;
    int unsigned stall_tick;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_mode <= 0;
            stall_tick <= 0;
            out_stall  <= 1'b0;
        end
        else
        begin
            stall_tick <= stall_tick + 1;
            if (stall_tick[5:0] == 6'd63)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Check each accepted result against the oldest queued read.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reads.size() == 0)
                report_mismatch("unexpected result, index", out_index, -1);
            else
            begin
                if (out_index !== pending_reads[0].index)
                    report_mismatch("out_index", out_index, pending_reads[0].index);
                if (ab_value !== pending_reads[0].ab)
                    report_mismatch("ab_value", ab_value, pending_reads[0].ab);
                if (ac_value !== pending_reads[0].ac)
                    report_mismatch("ac_value", ac_value, pending_reads[0].ac);
                void'(pending_reads.pop_front());
            end
        end
    end

    // Watchdog: end the run when nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        plan_row_t it;
        int        settle;
        error_count   = 0;
        burst_left    = 0;
        computes_done = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        kind          <= KIND_LOAD_WIN;
        index         <= '0;
        window_sample <= '0;
        b_sample      <= '0;
        c_sample      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Clear every sample so that no compute ever touches an unwritten entry.
        it = '{KIND_LOAD_WIN, 8'd0, 16'sd0, 16'sd0, 16'sd0, 0, '0, '0};
        for (int i = 0; i < N; i++)
        begin
            it.kind  = KIND_LOAD_WIN;
            it.index = INDEX_W'(i);
            send_item(it);
            it.kind = KIND_LOAD_SIG;
            send_item(it);
        end

        foreach (plan[i])
            send_item(plan[i]);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            // Hold off once midway until every queued read has come back.
            if (i == RAND_ITEMS / 2)
            begin
                in_valid <= 1'b0;
                wait (pending_reads.size() == 0);
                @(posedge clk);
            end
            send_item(random_item());
        end
        in_valid <= 1'b0;

        wait (pending_reads.size() == 0);
        settle = 0;
        while (settle < 20)
        begin
            @(posedge clk);
            settle++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
